### hdl/lkvc_pkg.sv
package lkvc_pkg;

    localparam int DEPTH   = 16;
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 32;
    localparam int RANK_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_NONE,
        OP_COMPARE,
        OP_PROMOTE,
        OP_INSERT
    } cell_op_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t            op;
        logic [KEY_W-1:0]    key;
        logic [VAL_W-1:0]    value;
        logic [RANK_W-1:0]   rank;   // compare: oldest rank, promote: rank of the hit
        logic                evict;  // insert: drop the oldest entry first
    } cell_cmd_t;

    // what each cell shows back to the controller
    typedef struct packed {
        logic                valid;
        logic                match;
        logic                victim;
        logic [RANK_W-1:0]   rank;
        logic [KEY_W-1:0]    key;
        logic [VAL_W-1:0]    value;
    } cell_stat_t;

endpackage

### hdl/lkvc_cell.sv
module lkvc_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lkvc_pkg::cell_cmd_t  cmd,
    input  logic                 taken_in,
    output logic                 taken_out,
    output lkvc_pkg::cell_stat_t stat
);

    logic                          valid_reg, valid_next;
    logic [lkvc_pkg::RANK_W-1:0]   rank_reg, rank_next;
    logic [lkvc_pkg::KEY_W-1:0]    key_reg;
    logic [lkvc_pkg::VAL_W-1:0]    value_reg;
    logic                          match_reg, victim_reg;
    logic                          drop;
    logic                          vacant;
    logic                          claim;

    // slot is free for an insert if empty or if its entry is the one evicted
    assign drop      = cmd.evict & victim_reg;
    assign vacant    = ~valid_reg | drop;
    assign claim     = (cmd.op == lkvc_pkg::OP_INSERT) & vacant & ~taken_in;
    assign taken_out = taken_in | vacant;

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        case (cmd.op)
            lkvc_pkg::OP_PROMOTE:
            begin
                if (match_reg)
                begin
                    rank_next = '0;
                end
                else if (valid_reg && (rank_reg < cmd.rank))
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            lkvc_pkg::OP_INSERT:
            begin
                if (claim)
                begin
                    valid_next = 1'b1;
                    rank_next  = '0;
                end
                else if (drop)
                begin
                    valid_next = 1'b0;
                    rank_next  = '0;
                end
                else if (valid_reg)
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            rank_reg   <= '0;
            match_reg  <= 1'b0;
            victim_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            if (cmd.op == lkvc_pkg::OP_COMPARE)
            begin
                match_reg  <= valid_reg & (key_reg == cmd.key);
                victim_reg <= valid_reg & (rank_reg == cmd.rank);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (claim)
        begin
            key_reg   <= cmd.key;
            value_reg <= cmd.value;
        end
    end

    assign stat.valid  = valid_reg;
    assign stat.match  = match_reg;
    assign stat.victim = victim_reg;
    assign stat.rank   = rank_reg;
    assign stat.key    = key_reg;
    assign stat.value  = value_reg;

endmodule

### hdl/lru_key_value_cache.sv
// Channel  Handshake            Payload
// -------  -------------------  ------------------------------------------
// in       in_valid / in_ready  mode, key, new_value
// out      out_valid/out_ready  hit, found_value, evicted, evicted_key
// cfg      cfg_wr_en            cfg_wr_data (capacity_in_use), no wait
//
// Each word passes an accept step, a compare cycle in which every cell
// matches the key and flags the oldest entry, and an update cycle in which
// the cells shift recency and the result is loaded into the output register.
// A new word is taken in the cycle after the update. Reset empties the
// cache and sets the capacity to 16. A result held by out_ready low holds
// the next word in its update cycle until the output register frees.
module lru_key_value_cache
(
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [lkvc_pkg::KEY_W-1:0]    key,
    input  logic [lkvc_pkg::VAL_W-1:0]    new_value,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic [lkvc_pkg::VAL_W-1:0]    found_value,
    output logic                          evicted,
    output logic [lkvc_pkg::KEY_W-1:0]    evicted_key,
    // capacity register
    input  logic                          cfg_wr_en,
    input  logic [lkvc_pkg::CNT_W-1:0]    cfg_wr_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPDATE
    } state_t;

    state_t                          state_reg;
    logic                            mode_reg;
    logic [lkvc_pkg::KEY_W-1:0]      key_reg;
    logic [lkvc_pkg::VAL_W-1:0]      value_reg;
    logic [lkvc_pkg::CNT_W-1:0]      cap_reg;
    logic [lkvc_pkg::CNT_W-1:0]      count_reg, count_next;

    logic                            out_valid_reg;
    logic                            hit_reg;
    logic [lkvc_pkg::VAL_W-1:0]      found_reg;
    logic                            evicted_reg;
    logic [lkvc_pkg::KEY_W-1:0]      evkey_reg;

    lkvc_pkg::cell_cmd_t             cmd;
    lkvc_pkg::cell_stat_t            stat [lkvc_pkg::DEPTH];
    logic [lkvc_pkg::DEPTH:0]        taken;
    logic [lkvc_pkg::DEPTH-1:0]      valid_vec, match_vec, victim_vec;

    logic                            any_hit;
    logic [lkvc_pkg::VAL_W-1:0]      hit_value;
    logic [lkvc_pkg::RANK_W-1:0]     hit_rank;
    logic [lkvc_pkg::KEY_W-1:0]      victim_key;
    logic [lkvc_pkg::CNT_W-1:0]      eff_cap;
    logic                            do_insert, do_evict;
    logic                            update_go;

    // capacity zero acts as one, anything past the row as the full row
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = lkvc_pkg::CNT_W'(1);
        end
        else if (cap_reg > lkvc_pkg::CNT_W'(lkvc_pkg::DEPTH))
        begin
            eff_cap = lkvc_pkg::CNT_W'(lkvc_pkg::DEPTH);
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    // gather the per-cell flags; keys are unique so at most one match
    always_comb
    begin
        any_hit    = 1'b0;
        hit_value  = '0;
        hit_rank   = '0;
        victim_key = '0;
        for (int i = 0; i < lkvc_pkg::DEPTH; i++)
        begin
            valid_vec[i]  = stat[i].valid;
            match_vec[i]  = stat[i].match;
            victim_vec[i] = stat[i].victim;
            any_hit       = any_hit | stat[i].match;
            hit_value     = hit_value  | (stat[i].value & {lkvc_pkg::VAL_W{stat[i].match}});
            hit_rank      = hit_rank   | (stat[i].rank  & {lkvc_pkg::RANK_W{stat[i].match}});
            victim_key    = victim_key | (stat[i].key   & {lkvc_pkg::KEY_W{stat[i].victim}});
        end
    end

    assign update_go = (state_reg == ST_UPDATE) & (~out_valid_reg | out_ready);
    assign do_insert = update_go & ~any_hit & mode_reg;
    // count at capacity implies at least one entry, so a victim exists
    assign do_evict  = do_insert & (count_reg >= eff_cap);

    always_comb
    begin
        cmd.op    = lkvc_pkg::OP_NONE;
        cmd.key   = key_reg;
        cmd.value = value_reg;
        cmd.rank  = hit_rank;
        cmd.evict = do_evict;
        if (state_reg == ST_LOOK)
        begin
            cmd.op   = lkvc_pkg::OP_COMPARE;
            // ranks of valid entries are always 0 .. count-1
            cmd.rank = count_reg[lkvc_pkg::RANK_W-1:0] - 1'b1;
        end
        else if (update_go)
        begin
            if (any_hit)
            begin
                cmd.op = lkvc_pkg::OP_PROMOTE;
            end
            else if (mode_reg)
            begin
                cmd.op = lkvc_pkg::OP_INSERT;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_insert && !do_evict)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // free-slot priority runs down the row, lowest index wins
    assign taken[0] = 1'b0;

    for (genvar g = 0; g < lkvc_pkg::DEPTH; g++)
    begin : g_cell
        lkvc_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .taken_in  (taken[g]),
            .taken_out (taken[g+1]),
            .stat      (stat[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= lkvc_pkg::CNT_W'(lkvc_pkg::DEPTH);
            count_reg     <= '0;
            mode_reg      <= 1'b0;
            key_reg       <= '0;
            value_reg     <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            found_reg     <= '0;
            evicted_reg   <= 1'b0;
            evkey_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            // a new result replaces the one leaving in the same cycle
            if (update_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            count_reg <= count_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg  <= mode;
                        key_reg   <= key;
                        value_reg <= new_value;
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    if (update_go)
                    begin
                        hit_reg       <= any_hit;
                        found_reg     <= hit_value;
                        evicted_reg   <= do_evict;
                        evkey_reg     <= do_evict ? victim_key : '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign found_value = found_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evkey_reg;

`ifndef SYNTHESIS
    // the count tracks the cells that hold an entry
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == count_reg)
        else $error("entry count differs from number of valid cells");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> $onehot0(match_vec))
        else $error("key matched in more than one cell");

    a_single_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && count_reg != '0) |-> $onehot(victim_vec))
        else $error("oldest entry not unique");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && evicted_reg))
        else $error("hit and eviction reported together");
`endif

endmodule

### tb/sv/lru_key_value_cache_tb.sv
`timescale 1ns / 100ps

module lru_key_value_cache_tb;

    // run length guard and pacing
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 90;   // long result stall, enough to back up the input
    localparam int POOL_SIZE     = 24;
    localparam int PHASE_WORDS   = 90;

    typedef struct {
        logic                       hit;
        logic [lkvc_pkg::VAL_W-1:0] found_value;
        logic                       evicted;
        logic [lkvc_pkg::KEY_W-1:0] evicted_key;
    } cache_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // request channel
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       mode = 1'b0;
    logic [lkvc_pkg::KEY_W-1:0] key = '0;
    logic [lkvc_pkg::VAL_W-1:0] new_value = '0;

    // result channel
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       hit;
    logic [lkvc_pkg::VAL_W-1:0] found_value;
    logic                       evicted;
    logic [lkvc_pkg::KEY_W-1:0] evicted_key;

    // capacity register
    logic                       cfg_wr_en = 1'b0;
    logic [lkvc_pkg::CNT_W-1:0] cfg_wr_data = '0;

    lru_key_value_cache dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .key         (key),
        .new_value   (new_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .found_value (found_value),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Shadow of the cache contents, updated as each request word is taken
    // ------------------------------------------------------------------
    logic                        slot_valid [lkvc_pkg::DEPTH];
    logic [lkvc_pkg::KEY_W-1:0]  slot_key   [lkvc_pkg::DEPTH];
    logic [lkvc_pkg::VAL_W-1:0]  slot_value [lkvc_pkg::DEPTH];
    logic [lkvc_pkg::RANK_W-1:0] slot_rank  [lkvc_pkg::DEPTH];   // 0 = most recently used
    logic [lkvc_pkg::CNT_W-1:0]  slot_count;
    logic [lkvc_pkg::CNT_W-1:0]  capacity_shadow;

    cache_result_t pending_results[$];
    cache_result_t oldest;
    int            mismatch_count = 0;

    // stimulus knobs
    bit            request_gaps_on = 1'b1;
    bit            result_stalls_on = 1'b1;
    bit            hold_request = 1'b0;
    logic [lkvc_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    // One access: hit search, promotion, and on an update miss the insert,
    // after evicting the oldest entry when the cache is at capacity.
    function automatic cache_result_t predict_access(logic is_update,
                                                     logic [lkvc_pkg::KEY_W-1:0] k,
                                                     logic [lkvc_pkg::VAL_W-1:0] v);
        cache_result_t               r;
        int                          match_slot;
        int                          free_slot;
        int                          victim;
        int                          limit;
        logic [lkvc_pkg::RANK_W-1:0] old_rank;
        logic [lkvc_pkg::RANK_W-1:0] worst;

        r.hit = 1'b0;
        r.found_value = '0;
        r.evicted = 1'b0;
        r.evicted_key = '0;
        match_slot = -1;
        free_slot = -1;
        for (int i = 0; i < lkvc_pkg::DEPTH; i++)
        begin
            if (slot_valid[i] && slot_key[i] == k && match_slot < 0)
                match_slot = i;
            if (!slot_valid[i] && free_slot < 0)
                free_slot = i;
        end

        // capacity 0 acts as 1, anything past DEPTH saturates
        limit = (capacity_shadow == 0) ? 1 : int'(capacity_shadow);
        if (limit > lkvc_pkg::DEPTH)
            limit = lkvc_pkg::DEPTH;

        if (match_slot >= 0)
        begin
            r.hit = 1'b1;
            r.found_value = slot_value[match_slot];
            old_rank = slot_rank[match_slot];
            for (int i = 0; i < lkvc_pkg::DEPTH; i++)
                if (slot_valid[i] && slot_rank[i] < old_rank)
                    slot_rank[i]++;
            slot_rank[match_slot] = '0;
        end
        else if (is_update)
        begin
            if (int'(slot_count) >= limit || free_slot < 0)
            begin
                victim = -1;
                worst = '0;
                for (int i = 0; i < lkvc_pkg::DEPTH; i++)
                begin
                    if (slot_valid[i] && (victim < 0 || slot_rank[i] > worst))
                    begin
                        victim = i;
                        worst = slot_rank[i];
                    end
                end
                if (victim >= 0)
                begin
                    r.evicted = 1'b1;
                    r.evicted_key = slot_key[victim];
                    slot_valid[victim] = 1'b0;
                    slot_rank[victim] = '0;
                    if (slot_count > 0)
                        slot_count--;
                    if (free_slot < 0 || victim < free_slot)
                        free_slot = victim;
                end
            end
            if (free_slot >= 0)
            begin
                for (int i = 0; i < lkvc_pkg::DEPTH; i++)
                    if (slot_valid[i])
                        slot_rank[i]++;
                slot_valid[free_slot] = 1'b1;
                slot_key[free_slot] = k;
                slot_value[free_slot] = v;
                slot_rank[free_slot] = '0;
                if (slot_count < lkvc_pkg::DEPTH)
                    slot_count++;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stall bursts, plus one long hold on request.
    // Only one nonblocking write to out_ready per clock edge.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int held;
        int burst;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            else if (result_stalls_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                burst = $urandom_range(1, 5);
                repeat (burst - 1) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Every result word is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (hit !== oldest.hit)
                begin
                    $error("hit: expected %0d, actual %0d", oldest.hit, hit);
                    mismatch_count++;
                end
                if (found_value !== oldest.found_value)
                begin
                    $error("found_value: expected %h, actual %h",
                           oldest.found_value, found_value);
                    mismatch_count++;
                end
                if (evicted !== oldest.evicted)
                begin
                    $error("evicted: expected %0d, actual %0d", oldest.evicted, evicted);
                    mismatch_count++;
                end
                if (evicted_key !== oldest.evicted_key)
                begin
                    $error("evicted_key: expected %h, actual %h",
                           oldest.evicted_key, evicted_key);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one word; valid stays up after acceptance so back-to-back words
    // never drop it in between. The prediction is made at the
    // accepting edge.
    task automatic send_word(logic m, logic [lkvc_pkg::KEY_W-1:0] k,
                             logic [lkvc_pkg::VAL_W-1:0] v);
        int gap;
        if (request_gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        key       <= k;
        new_value <= v;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        pending_results.push_back(predict_access(m, k, v));
    endtask

    // Mostly keys from a small pool so hits and evictions are common;
    // now and then a fresh random key.
    task automatic send_random_word(int pool_n);
        logic [lkvc_pkg::KEY_W-1:0] k;
        logic [lkvc_pkg::VAL_W-1:0] v;
        int                         pick;
        if ($urandom_range(0, 9) == 0)
            k = {$urandom, $urandom};
        else
            k = key_pool[$urandom_range(0, pool_n - 1)];
        pick = $urandom_range(0, 15);
        if (pick == 0)
            v = '0;
        else if (pick == 1)
            v = '1;
        else
            v = $urandom;
        send_word(1'($urandom_range(0, 1)), k, v);
    endtask

    // Stop offering, let every outstanding result come back, then settle.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Capacity is only written with the block idle.
    task automatic write_capacity(logic [lkvc_pkg::CNT_W-1:0] cap);
        wait_for_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        capacity_shadow = cap;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset capacity 16: misses on an empty cache, inserts at the key and
    // value extremes, hits, and update of a present key keeping its value.
    task automatic test_basic_access();
        send_word(1'b0, '0, '0);
        send_word(1'b0, '1, '1);
        send_word(1'b1, '0, '0);
        send_word(1'b1, '1, '1);
        send_word(1'b1, 64'h8000_0000_0000_0001, 32'h8000_0001);
        send_word(1'b0, '1, 32'h1111_1111);
        send_word(1'b0, '0, '1);
        send_word(1'b1, '1, 32'h0000_1234);   // refresh, old value stays
        send_word(1'b0, '1, '0);
        send_word(1'b1, '0, 32'hDEAD_BEEF);
        send_word(1'b0, 64'h5555_5555_5555_5555, '0);
    endtask

    // Capacity 3: promotion by lookup changes which entry goes next.
    task automatic test_lru_order();
        write_capacity(5'd3);
        send_word(1'b1, 64'hA, 32'hA0);
        send_word(1'b1, 64'hB, 32'hB0);
        send_word(1'b1, 64'hC, 32'hC0);
        send_word(1'b0, 64'hA, '0);           // A becomes most recent
        send_word(1'b1, 64'hD, 32'hD0);       // B goes
        send_word(1'b0, 64'hB, '0);
        send_word(1'b1, 64'hE, 32'hE0);       // C goes
        send_word(1'b0, 64'hA, '0);
        send_word(1'b0, 64'hD, '0);
        send_word(1'b1, 64'hB, 32'hB1);       // E goes
    endtask

    // Random traffic at a series of capacities: zero, one, small, full, above
    // DEPTH, the maximum code, lowered below the entry count, then random codes.
    task automatic test_capacity_sweep();
        logic [lkvc_pkg::CNT_W-1:0] caps [11];
        int                         pool_n;
        caps = '{5'd0, 5'd1, 5'd2, 5'd8, 5'd16, 5'd17, 5'd31, 5'd2, 5'd0, 5'd0, 5'd0};
        for (int p = 8; p < 11; p++)
            caps[p] = lkvc_pkg::CNT_W'($urandom_range(0, 31));
        foreach (caps[p])
        begin
            write_capacity(caps[p]);
            pool_n = (caps[p] > lkvc_pkg::DEPTH) ? lkvc_pkg::DEPTH + 4 : int'(caps[p]) + 4;
            if (pool_n > POOL_SIZE)
                pool_n = POOL_SIZE;
            repeat (PHASE_WORDS) send_random_word(pool_n);
        end
    endtask

    // Results held off for a long stretch while words keep coming, so the
    // block backs up and drops in_ready.
    task automatic test_result_backpressure();
        write_capacity(5'd16);
        request_gaps_on = 1'b0;
        hold_request = 1'b1;
        repeat (40) send_random_word(POOL_SIZE);
        request_gaps_on = 1'b1;
    endtask

    // Sender goes quiet until everything is back, then resumes.
    task automatic test_request_pause();
        repeat (25) send_random_word(20);
        wait_for_idle();
        repeat (25) send_random_word(20);
    endtask

    // Last stretch at full rate with no idling on either side.
    task automatic test_full_rate_stream();
        write_capacity(5'd16);
        request_gaps_on = 1'b0;
        result_stalls_on = 1'b0;
        repeat (800) send_random_word(20);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        foreach (slot_valid[i])
        begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_rank[i]  = '0;
        end
        slot_count = '0;
        capacity_shadow = 5'd16;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_access();
        test_lru_order();
        test_capacity_sweep();
        test_result_backpressure();
        test_request_pause();
        test_full_rate_stream();

        wait_for_idle();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
